// ===== src/fqks_pkg.sv =====
// Shared constants and codes for the FIFO queue with key search.
package fqks_pkg;

  // Default sizing
  localparam int unsigned DEPTH_DEF     = 16;
  localparam int unsigned NAME_BITS_DEF = 64;

  // Field widths
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned NAME_W   = 64;
  localparam int unsigned PRICE_W  = 32;
  localparam int unsigned QPOS_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned POS_W    = 5;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned S_TDATA_W = NAME_W + PRICE_W + QPOS_W;
  localparam int unsigned M_TDATA_RAW_W = POS_W + NAME_W + PRICE_W;
  localparam int unsigned M_TDATA_W = ((M_TDATA_RAW_W + 7) / 8) * 8;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FIND   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LIST   = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd6;
  localparam logic [STATUS_W-1:0] ST_LIST      = 3'd7;

endpackage

// ===== src/fqks_ram.sv =====
// Generic single-port RAM with registered read.
module fqks_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/fifo_queue_with_key_search_unit.sv =====
// Top level: bounded FIFO of name/price entries with append, remove, find, read and list.
//
// Holds up to DEPTH entries (a NAME_BITS-bit name key and a 32-bit price in
// cents) in a circular buffer in one single-port RAM. One request is taken at
// a time; s_axis_tready_o is low until the request's last result has gone
// into the output register. Append, and any request that fails on a bound
// check (full, empty, position zero, position past the count), produces its
// result through S_EMIT. Remove and read-by-position go through S_RD (RAM
// read), then S_CHK (result). Find examines entries front first, an S_RD and
// an S_CHK per entry, and stops at the first hit; when nothing matches it
// reports not-found through S_EMIT. List makes an S_RD and S_CHK pass per
// entry, one result each. This pacing comes from the RAM's registered read
// port and the single key comparator, walked one entry at a time by the
// sequencer. Output stalls hold it in S_EMIT or S_CHK. No clearing pass after
// reset: stored entries are only ever read after they have been written.
// Unused command codes are accepted and dropped without a result.
module fifo_queue_with_key_search_unit #(
  parameter int unsigned DEPTH     = fqks_pkg::DEPTH_DEF,
  parameter int unsigned NAME_BITS = fqks_pkg::NAME_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request channel
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // tdata: item_name[63:0], item_price[95:64], query_position[103:96]
  input  logic [fqks_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // tuser: command[2:0]
  input  logic [fqks_pkg::CMD_W-1:0]      s_axis_tuser_i,
  // result channel
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // tdata: entry_position[4:0], entry_name[68:5], entry_price[100:69], zero pad
  output logic [fqks_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,
  // tuser: status[2:0]
  output logic [fqks_pkg::STATUS_W-1:0]   m_axis_tuser_o,
  // tlast: last_result
  output logic                            m_axis_tlast_o
);

  import fqks_pkg::*;

  localparam int unsigned AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned RW  = NAME_BITS + PRICE_W;
  localparam int unsigned QCW = QPOS_W + 1;

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EMIT = 2'd1;  // single pending result
  localparam logic [1:0] S_RD   = 2'd2;  // issue RAM read for idx_q
  localparam logic [1:0] S_CHK  = 2'd3;  // RAM data valid, compare / report

  // Request fields
  logic [NAME_BITS-1:0] in_name;
  logic [PRICE_W-1:0]   in_price;
  logic [QPOS_W-1:0]    in_qpos;

  assign in_name  = s_axis_tdata_i[NAME_BITS-1:0];
  assign in_price = s_axis_tdata_i[NAME_W +: PRICE_W];
  assign in_qpos  = s_axis_tdata_i[NAME_W + PRICE_W +: QPOS_W];

  // State
  logic [1:0]            state_q, state_d;
  logic [CMD_W-1:0]      cmd_q, cmd_d;
  logic [NAME_BITS-1:0]  key_q, key_d;
  logic [AW-1:0]         idx_q, idx_d;
  logic [AW-1:0]         front_q, front_d;
  logic [CW-1:0]         count_q, count_d;

  // Pending single result
  logic [STATUS_W-1:0]   res_status_q, res_status_d;
  logic [POS_W-1:0]      res_pos_q, res_pos_d;
  logic [NAME_W-1:0]     res_name_q, res_name_d;
  logic [PRICE_W-1:0]    res_price_q, res_price_d;

  // Output register
  logic                  out_valid_q;
  logic [STATUS_W-1:0]   out_status_q;
  logic [POS_W-1:0]      out_pos_q;
  logic [NAME_W-1:0]     out_name_q;
  logic [PRICE_W-1:0]    out_price_q;
  logic                  out_last_q;
  logic                  out_free;

  // Emission into the output register
  logic                  emit;
  logic [STATUS_W-1:0]   emit_status;
  logic [POS_W-1:0]      emit_pos;
  logic [NAME_W-1:0]     emit_name;
  logic [PRICE_W-1:0]    emit_price;
  logic                  emit_last;

  // RAM
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_addr;
  logic [RW-1:0]         ram_rdata;
  logic [NAME_BITS-1:0]  rd_name;
  logic [PRICE_W-1:0]    rd_price;

  // Address arithmetic
  logic [AW-1:0]         offset;
  logic [AW:0]           slot_sum;
  logic [CW-1:0]         idx_inc;
  logic                  idx_last;
  logic                  key_hit;
  logic                  accept;

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  // (front + offset) mod DEPTH; both terms below DEPTH
  assign offset   = (state_q == S_IDLE) ? AW'(count_q) : idx_q;
  assign slot_sum = (AW+1)'(front_q) + (AW+1)'(offset);
  assign ram_addr = (slot_sum >= (AW+1)'(DEPTH)) ? AW'(slot_sum - (AW+1)'(DEPTH))
                                                : AW'(slot_sum);

  assign idx_inc  = CW'(idx_q) + CW'(1);
  assign idx_last = (idx_inc == count_q);

  assign rd_name  = ram_rdata[NAME_BITS-1:0];
  assign rd_price = ram_rdata[NAME_BITS +: PRICE_W];
  assign key_hit  = (rd_name == key_q);   // the one shared comparator

  fqks_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i ({in_price, in_name}),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    idx_d        = idx_q;
    front_d      = front_q;
    count_d      = count_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_name_d   = res_name_q;
    res_price_d  = res_price_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    emit         = 1'b0;
    emit_status  = res_status_q;
    emit_pos     = res_pos_q;
    emit_name    = res_name_q;
    emit_price   = res_price_q;
    emit_last    = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d       = s_axis_tuser_i;
          key_d       = in_name;
          idx_d       = '0;
          res_pos_d   = '0;
          res_name_d  = '0;
          res_price_d = '0;
          case (s_axis_tuser_i)
            CMD_APPEND: begin
              state_d = S_EMIT;
              if (count_q == CW'(DEPTH)) begin
                res_status_d = ST_FULL;
              end else begin
                ram_we       = 1'b1;
                count_d      = count_q + CW'(1);
                res_status_d = ST_ADDED;
                res_pos_d    = POS_W'(count_q + CW'(1));
                res_name_d   = NAME_W'(in_name);
                res_price_d  = in_price;
              end
            end
            CMD_REMOVE, CMD_FIND, CMD_LIST: begin
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
                state_d      = S_EMIT;
              end else begin
                state_d = S_RD;
              end
            end
            CMD_READ: begin
              state_d = S_EMIT;
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
              end else if (in_qpos == '0) begin
                res_status_d = ST_INVALID;
              end else if ({1'b0, in_qpos} > QCW'(count_q)) begin
                res_status_d = ST_NOT_FOUND;
              end else begin
                idx_d   = AW'(in_qpos - QPOS_W'(1));
                state_d = S_RD;
              end
            end
            default: begin
              state_d = S_IDLE;   // unused code: dropped
            end
          endcase
        end
      end

      S_EMIT: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_RD: begin
        ram_re  = 1'b1;
        state_d = S_CHK;
      end

      S_CHK: begin
        emit_pos   = POS_W'(idx_inc);
        emit_name  = NAME_W'(rd_name);
        emit_price = rd_price;
        case (cmd_q)
          CMD_REMOVE: begin
            emit_status = ST_REMOVED;
            if (out_free) begin
              emit    = 1'b1;
              front_d = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);
              count_d = count_q - CW'(1);
              state_d = S_IDLE;
            end
          end
          CMD_FIND: begin
            emit_status = ST_FOUND;
            if (key_hit) begin
              if (out_free) begin
                emit    = 1'b1;
                state_d = S_IDLE;
              end
            end else if (idx_last) begin
              res_status_d = ST_NOT_FOUND;
              state_d      = S_EMIT;
            end else begin
              idx_d   = idx_q + AW'(1);
              state_d = S_RD;
            end
          end
          CMD_LIST: begin
            emit_status = ST_LIST;
            emit_last   = idx_last;
            if (out_free) begin
              emit = 1'b1;
              if (idx_last) begin
                state_d = S_IDLE;
              end else begin
                idx_d   = idx_q + AW'(1);
                state_d = S_RD;
              end
            end
          end
          default: begin
            // read by position
            emit_status = ST_FOUND;
            if (out_free) begin
              emit    = 1'b1;
              state_d = S_IDLE;
            end
          end
        endcase
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_name_q   <= res_name_d;
    res_price_q  <= res_price_d;
    if (emit) begin
      out_status_q <= emit_status;
      out_pos_q    <= emit_pos;
      out_name_q   <= emit_name;
      out_price_q  <= emit_price;
      out_last_q   <= emit_last;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = M_TDATA_W'({out_price_q, out_name_q, out_pos_q});

  // Occupancy never passes the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above capacity");

  // Front pointer stays inside the buffer
  a_front_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (AW+1)'(front_q) < (AW+1)'(DEPTH))
    else $error("front pointer out of range");

  // A RAM read is only issued for a stored entry
  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> (count_q != '0) && (CW'(idx_q) < count_q))
    else $error("read of an entry beyond the count");

  // After a final result the sequencer is back to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_last) |=> (state_q == S_IDLE))
    else $error("sequencer busy after final result");

endmodule
